/* rtl/glosd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package glosd_pkg;

	// map and number format
	localparam int MAP_DIM   = 64;
	localparam int FRAC_BITS = 8;
	localparam int COORD_W   = 14;
	localparam int CELL_W    = COORD_W - FRAC_BITS;
	localparam int MAP_IDX_W = $clog2(MAP_DIM);
	localparam int MAP_AW    = 2 * MAP_IDX_W;

	// walk datapath widths: cell position carries a sign and one cell of overshoot
	localparam int POS_W  = CELL_W + 2;
	localparam int BND_W  = FRAC_BITS + 1;
	localparam int BX_W   = FRAC_BITS + CELL_W + 2;
	localparam int PROD_W = BX_W + COORD_W;
	localparam int SQ_W   = 2 * COORD_W;
	localparam int STEP_W = 8;

	// configuration registers
	localparam int CFG_W   = 7;
	localparam int RNG_W   = CFG_W + FRAC_BITS;
	localparam int RSQ_W   = 2 * RNG_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MAX_RANGE  = 2'd2;

	localparam logic [CFG_W-1:0] RST_MAP_WIDTH  = 7'd64;
	localparam logic [CFG_W-1:0] RST_MAP_HEIGHT = 7'd64;
	localparam logic [CFG_W-1:0] RST_MAX_RANGE  = 7'd15;

	// request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// job classes handed from front to back
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_FAR   = 2'd1;
	localparam logic [1:0] KIND_NEAR  = 2'd2;
	localparam logic [1:0] KIND_WALK  = 2'd3;

	// outcome codes
	localparam logic [1:0] OUT_VISIBLE = 2'd0;
	localparam logic [1:0] OUT_FAR     = 2'd1;
	localparam logic [1:0] OUT_LEFT    = 2'd2;
	localparam logic [1:0] OUT_SOLID   = 2'd3;

	// one whole cell in boundary distance units
	localparam logic [BND_W-1:0] BND_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic [CFG_W-1:0] map_width;
		logic [CFG_W-1:0] map_height;
		logic [CFG_W-1:0] max_range;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              solid;
		logic [CELL_W-1:0] cx;
		logic [CELL_W-1:0] cy;
		logic [CELL_W-1:0] tx;
		logic [CELL_W-1:0] ty;
		logic              negx;
		logic              negy;
		logic [COORD_W-1:0] adx;
		logic [COORD_W-1:0] ady;
		logic [BND_W-1:0]  bx;
		logic [BND_W-1:0]  by;
	} job_t;

endpackage

`default_nettype wire

/* rtl/glosd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module glosd_front
	import glosd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               hold,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               func,
	input  wire logic [CELL_W-1:0]  cell_x,
	input  wire logic [CELL_W-1:0]  cell_y,
	input  wire logic               mark_solid,
	input  wire logic [COORD_W-1:0] from_x,
	input  wire logic [COORD_W-1:0] from_y,
	input  wire logic [COORD_W-1:0] to_x,
	input  wire logic [COORD_W-1:0] to_y,
	output logic                    job_valid,
	output job_t                    job,
	input  wire logic               job_space
);

	logic en;
	logic acc;
	logic v_s1, v_s2;

	logic               func_s1, solid_s1, negx_s1, negy_s1;
	logic [CELL_W-1:0]  wx_s1, wy_s1, tx_s1, ty_s1;
	logic [COORD_W-1:0] fx_s1, fy_s1, adx_s1, ady_s1;
	logic [RNG_W-1:0]   rng_s1;

	logic               func_s2, solid_s2, negx_s2, negy_s2;
	logic [CELL_W-1:0]  wx_s2, wy_s2, tx_s2, ty_s2;
	logic [COORD_W-1:0] fx_s2, fy_s2, adx_s2, ady_s2;
	logic [SQ_W-1:0]    sqx_s2, sqy_s2;
	logic [RSQ_W-1:0]   rsq_s2;

	logic [SQ_W:0]          dsq;
	logic                   far;
	logic                   same;
	logic [CELL_W-1:0]      fcx, fcy;
	logic [FRAC_BITS-1:0]   frx, fry;

	// pipeline moves whenever its last stage can hand over
	assign en       = !v_s2 || job_space;
	assign in_stall = hold || !en;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	// stage 1: capture and take absolute differences
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1  <= func;
			solid_s1 <= mark_solid;
			wx_s1    <= cell_x;
			wy_s1    <= cell_y;
			fx_s1    <= from_x;
			fy_s1    <= from_y;
			tx_s1    <= to_x[COORD_W-1:FRAC_BITS];
			ty_s1    <= to_y[COORD_W-1:FRAC_BITS];
			negx_s1  <= to_x < from_x;
			negy_s1  <= to_y < from_y;
			adx_s1   <= (to_x < from_x) ? from_x - to_x : to_x - from_x;
			ady_s1   <= (to_y < from_y) ? from_y - to_y : to_y - from_y;
			rng_s1   <= {cfg.max_range, {FRAC_BITS{1'b0}}};
		end
	end

	// stage 2: squares for the range test
	always_ff @(posedge clk) begin
		if (en) begin
			func_s2  <= func_s1;
			solid_s2 <= solid_s1;
			wx_s2    <= wx_s1;
			wy_s2    <= wy_s1;
			fx_s2    <= fx_s1;
			fy_s2    <= fy_s1;
			tx_s2    <= tx_s1;
			ty_s2    <= ty_s1;
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			adx_s2   <= adx_s1;
			ady_s2   <= ady_s1;
			sqx_s2   <= adx_s1 * adx_s1;
			sqy_s2   <= ady_s1 * ady_s1;
			rsq_s2   <= rng_s1 * rng_s1;
		end
	end

	// classification of the request
	assign dsq  = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign far  = {{(RSQ_W - SQ_W - 1){1'b0}}, dsq} > rsq_s2;
	assign fcx  = fx_s2[COORD_W-1:FRAC_BITS];
	assign fcy  = fy_s2[COORD_W-1:FRAC_BITS];
	assign frx  = fx_s2[FRAC_BITS-1:0];
	assign fry  = fy_s2[FRAC_BITS-1:0];
	assign same = (fcx == tx_s2) && (fcy == ty_s2);

	always_comb begin
		job_valid = v_s2;
		if (func_s2 == FUNC_WRITE) begin
			job.kind = KIND_WRITE;
		end else if (far) begin
			job.kind = KIND_FAR;
		end else if (same) begin
			job.kind = KIND_NEAR;
		end else begin
			job.kind = KIND_WALK;
		end
		job.solid = solid_s2;
		job.cx    = (func_s2 == FUNC_WRITE) ? wx_s2 : fcx;
		job.cy    = (func_s2 == FUNC_WRITE) ? wy_s2 : fcy;
		job.tx    = tx_s2;
		job.ty    = ty_s2;
		job.negx  = negx_s2;
		job.negy  = negy_s2;
		job.adx   = adx_s2;
		job.ady   = ady_s2;
		// distance to the first cell edge on each axis
		job.bx    = negx_s2 ? {1'b0, frx} : BND_ONE - {1'b0, frx};
		job.by    = negy_s2 ? {1'b0, fry} : BND_ONE - {1'b0, fry};
	end

endmodule

`default_nettype wire

/* rtl/glosd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module glosd_queue
	import glosd_pkg::*;
#(
	parameter int DEPTH = 2
)
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_data,
	output logic      space,
	output logic      avail,
	input  wire logic pop,
	output job_t      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign space    = cnt_q != CNT_W'(DEPTH);
	assign avail    = cnt_q != '0;
	assign do_push  = push && space;
	assign do_pop   = pop && avail;
	assign pop_data = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/glosd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module glosd_back
	import glosd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire logic         job_valid,
	input  wire job_t         job,
	output logic              job_pop,
	output logic              clearing,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              visible,
	output logic [1:0]        outcome,
	output logic [STEP_W-1:0] cells_stepped
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_SOLID = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	localparam logic [BX_W-1:0]   BX_ONE   = BX_W'(BND_ONE);
	localparam logic [CFG_W-1:0]  DIM_MAX  = CFG_W'(MAP_DIM);
	localparam logic [STEP_W-1:0] STEP_SAT = '1;

	logic [2:0]         st_q;
	logic [MAP_AW-1:0]  clr_q;

	logic               negx_q, negy_q;
	logic [COORD_W-1:0] adx_q, ady_q;
	logic [BX_W-1:0]    bx_q, by_q;
	logic [POS_W-1:0]   cx_q, cy_q;
	logic [CELL_W-1:0]  tx_q, ty_q;
	logic [STEP_W-1:0]  steps_q;
	logic [PROD_W-1:0]  prodx_q, prody_q;

	logic               res_vis_q;
	logic [1:0]         res_out_q;
	logic [STEP_W-1:0]  res_steps_q;

	logic               out_valid_q;
	logic               vis_q;
	logic [1:0]         outcome_q;
	logic [STEP_W-1:0]  steps_out_q;

	logic               map_mem [MAP_DIM * MAP_DIM];
	logic               rd_q;
	logic               mem_we;
	logic [MAP_AW-1:0]  mem_wa, mem_ra;
	logic               mem_wd;

	logic [CFG_W-1:0]   w_lim, h_lim;
	logic               stepx;
	logic [POS_W-1:0]   nx, ny;
	logic [STEP_W-1:0]  steps_nx;
	logic               hit, outside;
	logic               emit_go;

	// map size saturates at the store size
	assign w_lim = (cfg.map_width > DIM_MAX) ? DIM_MAX : cfg.map_width;
	assign h_lim = (cfg.map_height > DIM_MAX) ? DIM_MAX : cfg.map_height;

	// next cell of the walk, from the registered crossing products
	always_comb begin
		if (adx_q == '0) begin
			stepx = 1'b0;
		end else if (ady_q == '0) begin
			stepx = 1'b1;
		end else begin
			stepx = prodx_q < prody_q;
		end
		nx = cx_q;
		ny = cy_q;
		if (stepx) begin
			nx = negx_q ? cx_q - POS_W'(1) : cx_q + POS_W'(1);
		end else begin
			ny = negy_q ? cy_q - POS_W'(1) : cy_q + POS_W'(1);
		end
		steps_nx = (steps_q == STEP_SAT) ? STEP_SAT : steps_q + STEP_W'(1);
		hit      = (nx == POS_W'(tx_q)) && (ny == POS_W'(ty_q));
		outside  = nx[POS_W-1] || ny[POS_W-1] ||
			(nx >= POS_W'(w_lim)) || (ny >= POS_W'(h_lim));
	end

	assign clearing = st_q == ST_CLEAR;
	assign job_pop  = (st_q == ST_IDLE) && job_valid;
	assign emit_go  = (st_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// map store port: clearing pass and cell writes, reads for the walk
	assign mem_we = clearing || (job_pop && job.kind == KIND_WRITE);
	assign mem_wa = clearing ? clr_q : {job.cy[MAP_IDX_W-1:0], job.cx[MAP_IDX_W-1:0]};
	assign mem_wd = clearing ? 1'b0 : job.solid;
	assign mem_ra = {ny[MAP_IDX_W-1:0], nx[MAP_IDX_W-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		rd_q <= map_mem[mem_ra];
	end

	// crossing time products, refreshed every cycle
	always_ff @(posedge clk) begin
		prodx_q <= bx_q * ady_q;
		prody_q <= by_q * adx_q;
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MAP_AW'(1);
					if (clr_q == '1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (job_valid) begin
						case (job.kind)
							KIND_FAR:  st_q <= ST_EMIT;
							KIND_NEAR: st_q <= ST_EMIT;
							KIND_WALK: st_q <= ST_PREP;
							default:   st_q <= ST_IDLE;
						endcase
					end
				end
				ST_PREP: begin
					st_q <= ST_STEP;
				end
				ST_STEP: begin
					if (hit || outside) begin
						st_q <= ST_EMIT;
					end else begin
						st_q <= ST_SOLID;
					end
				end
				ST_SOLID: begin
					st_q <= rd_q ? ST_EMIT : ST_STEP;
				end
				ST_EMIT: begin
					if (emit_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk datapath and decision
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				negx_q  <= job.negx;
				negy_q  <= job.negy;
				adx_q   <= job.adx;
				ady_q   <= job.ady;
				bx_q    <= BX_W'(job.bx);
				by_q    <= BX_W'(job.by);
				cx_q    <= POS_W'(job.cx);
				cy_q    <= POS_W'(job.cy);
				tx_q    <= job.tx;
				ty_q    <= job.ty;
				steps_q <= '0;
				res_vis_q   <= job.kind == KIND_NEAR;
				res_out_q   <= (job.kind == KIND_NEAR) ? OUT_VISIBLE : OUT_FAR;
				res_steps_q <= '0;
			end
			ST_STEP: begin
				cx_q    <= nx;
				cy_q    <= ny;
				steps_q <= steps_nx;
				if (stepx) begin
					bx_q <= bx_q + BX_ONE;
				end else begin
					by_q <= by_q + BX_ONE;
				end
				res_vis_q   <= hit;
				res_out_q   <= hit ? OUT_VISIBLE : OUT_LEFT;
				res_steps_q <= steps_nx;
			end
			ST_SOLID: begin
				res_vis_q   <= 1'b0;
				res_out_q   <= OUT_SOLID;
				res_steps_q <= steps_q;
			end
			default: begin
			end
		endcase
	end

	// result register towards the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			vis_q       <= res_vis_q;
			outcome_q   <= res_out_q;
			steps_out_q <= res_steps_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign visible       = vis_q;
	assign outcome       = outcome_q;
	assign cells_stepped = steps_out_q;

endmodule

`default_nettype wire

/* rtl/grid_line_of_sight_dda_core.sv */
// grid line-of-sight core
// Input channel (in_valid / in_stall) takes one request per accepted edge:
// func 0 writes cell (cell_x, cell_y) of the solid map with mark_solid and
// gives no result; func 1 asks whether (to_x, to_y) is seen from
// (from_x, from_y), both with 8 fraction bits. Each query gives one result
// on the output channel (out_valid / out_stall): visible, outcome and the
// number of cells stepped. Map size and sight range sit in three registers
// on the APB port; the user must write them only while the core is idle,
// as the core does not enforce it. A query passes a two-stage front end,
// a small job queue and the walker. After a set-up state the walker takes
// each cell step as a step with map read, then the solid check; writes are
// done as the walker takes them, and rejected queries skip the walk.
// Up to QUEUE_DEPTH jobs wait between front and walker, so requests keep
// being taken while a walk runs. After reset the map is swept clear, one
// cell per cycle over all 4096 cells, and in_stall stays high until the
// sweep ends. A stalled result holds in the output register; the walker
// then waits and the queue fills up.
`timescale 1ns / 1ps
`default_nettype none

module grid_line_of_sight_dda_core
	import glosd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
)
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               func,
	input  wire logic [CELL_W-1:0]  cell_x,
	input  wire logic [CELL_W-1:0]  cell_y,
	input  wire logic               mark_solid,
	input  wire logic [COORD_W-1:0] from_x,
	input  wire logic [COORD_W-1:0] from_y,
	input  wire logic [COORD_W-1:0] to_x,
	input  wire logic [COORD_W-1:0] to_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    visible,
	output logic [1:0]              outcome,
	output logic [STEP_W-1:0]       cells_stepped
);

	logic [CFG_W-1:0] map_width_q, map_height_q, max_range_q;
	logic [1:0]       reg_idx;
	logic             reg_wr;
	cfg_t             cfg;

	logic job_valid, job_space, job_avail, job_pop, clearing;
	job_t job_in, job_out;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= RST_MAP_WIDTH;
			map_height_q <= RST_MAP_HEIGHT;
			max_range_q  <= RST_MAX_RANGE;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_MAP_WIDTH:  map_width_q  <= pwdata[CFG_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[CFG_W-1:0];
				REG_MAX_RANGE:  max_range_q  <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAP_WIDTH:  prdata = PDATA_W'(map_width_q);
			REG_MAP_HEIGHT: prdata = PDATA_W'(map_height_q);
			REG_MAX_RANGE:  prdata = PDATA_W'(max_range_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg = '{map_width: map_width_q, map_height: map_height_q,
		max_range: max_range_q};

	// request intake and classification
	glosd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clearing),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.mark_solid (mark_solid),
		.from_x     (from_x),
		.from_y     (from_y),
		.to_x       (to_x),
		.to_y       (to_y),
		.job_valid  (job_valid),
		.job        (job_in),
		.job_space  (job_space)
	);

	// job queue between front and walker
	glosd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid),
		.push_data (job_in),
		.space     (job_space),
		.avail     (job_avail),
		.pop       (job_pop),
		.pop_data  (job_out)
	);

	// map store and walker
	glosd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.job_valid     (job_avail),
		.job           (job_out),
		.job_pop       (job_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.visible       (visible),
		.outcome       (outcome),
		.cells_stepped (cells_stepped)
	);

endmodule

`default_nettype wire

/* rtl/glosd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module glosd_checker
	import glosd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              visible,
	input wire logic [1:0]        outcome,
	input wire logic [STEP_W-1:0] cells_stepped
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({visible, outcome, cells_stepped}))
		else $error("result changed while stalled");

	// visible flag agrees with the outcome code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> visible == (outcome == OUT_VISIBLE))
		else $error("visible flag and outcome disagree");

	// a range reject never walks
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_FAR |-> cells_stepped == '0)
		else $error("too far result with steps");

	// a blocked sight needs at least one step
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUT_LEFT || outcome == OUT_SOLID) |->
		cells_stepped != '0)
		else $error("blocked result without steps");

endmodule

bind grid_line_of_sight_dda_core glosd_checker u_glosd_checker (.*);

`default_nettype wire
